/* src/rril_pkg.sv */
// ----------------------------------------------------------------------------
// rril_pkg: shared types and constants for the register image loader
// Request structs, the record parser phase and the queue depth default.
// ----------------------------------------------------------------------------
package rril_pkg;

    localparam int WORD_QUEUE_DEPTH = 4;

    localparam logic [15:0] RUN_FLAG = 16'h8000;
    localparam logic [14:0] LEN_MASK = 15'h7FFF;

    // One byte of the image stream.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } byte_req_t;

    // One register write.
    typedef struct packed {
        logic [7:0]  reg_addr;
        logic [15:0] reg_value;
        logic [14:0] repeat_count;
    } reg_wr_t;

    // Assembled little-endian word; restart marks the first word of an image.
    typedef struct packed {
        logic        restart;
        logic [15:0] word;
    } word_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    typedef enum logic [1:0] {
        PH_ADDR    = 2'd0,
        PH_COUNT   = 2'd1,
        PH_RUNVAL  = 2'd2,
        PH_COPYVAL = 2'd3
    } phase_t;

endpackage

/* src/rril_queue.sv */
// ----------------------------------------------------------------------------
// rril_queue: word queue between byte front end and record parser
// Small register FIFO; reads come straight from the head entry.
// ----------------------------------------------------------------------------
module rril_queue
    import rril_pkg::*;
#(
    parameter int DEPTH = WORD_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  word_entry_t push_data,
    input  logic        pop,
    output word_entry_t pop_data,
    output queue_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    word_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == FULL_CNT);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/rril_front.sv */
// ----------------------------------------------------------------------------
// rril_front: byte pairing front end
// Joins bytes into little-endian words and tags image restarts.
// ----------------------------------------------------------------------------
module rril_front
    import rril_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  byte_req_t   byte_req,
    input  queue_stat_t q_stat,
    output logic        q_push,
    output word_entry_t q_data
);

    logic       odd_reg, odd_next;
    logic       start_reg, start_next;
    logic [7:0] low_reg, low_next;
    logic       take;
    logic       hold_low;

    // Conservative: stall whenever the queue is full.
    assign byte_stall = q_stat.full;
    assign take       = byte_valid && !byte_stall;
    // stream_start drops any held byte and begins a new word.
    assign hold_low   = byte_req.stream_start || !odd_reg;
    assign q_push     = take && !hold_low;
    assign q_data     = '{restart: start_reg, word: {byte_req.data_byte, low_reg}};

    always_comb
    begin
        odd_next   = odd_reg;
        start_next = start_reg;
        low_next   = low_reg;
        if (take)
        begin
            if (hold_low)
            begin
                odd_next   = 1'b1;
                start_next = byte_req.stream_start;
                low_next   = byte_req.data_byte;
            end
            else
            begin
                odd_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_reg   <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            odd_reg   <= odd_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg <= low_next;
    end

endmodule

/* src/rril_back.sv */
// ----------------------------------------------------------------------------
// rril_back: record parser and write output register
// Walks address, count and value words; a write per value, none for a zero run.
// ----------------------------------------------------------------------------
module rril_back
    import rril_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_stat_t q_stat,
    input  word_entry_t q_data,
    output logic        q_pop,
    output logic        wr_valid,
    input  logic        wr_stall,
    output reg_wr_t     wr_req
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  addr_reg, addr_next;
    logic [14:0] left_reg, left_next;
    logic        out_vld_reg, out_vld_next;
    reg_wr_t     out_reg, out_next;

    phase_t      cur_phase;
    logic [14:0] cur_left;
    logic [14:0] copy_left;
    logic        emit;
    reg_wr_t     emit_req;
    logic        out_free;

    assign out_free  = !out_vld_reg || !wr_stall;
    assign q_pop     = !q_stat.empty && out_free;
    // A restart word always parses as an address word.
    assign cur_phase = q_data.restart ? PH_ADDR : phase_reg;
    assign cur_left  = q_data.restart ? '0 : left_reg;
    assign copy_left = (cur_left != '0) ? cur_left - 1'b1 : '0;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        if (q_pop)
        begin
            case (cur_phase)
                PH_ADDR:
                begin
                    addr_next  = q_data.word[7:0];
                    left_next  = cur_left;
                    phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    left_next = q_data.word[14:0] & LEN_MASK;
                    if ((q_data.word & RUN_FLAG) != '0)
                    begin
                        phase_next = PH_RUNVAL;
                    end
                    else if (q_data.word[14:0] != '0)
                    begin
                        phase_next = PH_COPYVAL;
                    end
                    else
                    begin
                        phase_next = PH_ADDR;
                    end
                end
                PH_RUNVAL:
                begin
                    left_next  = '0;
                    phase_next = PH_ADDR;
                end
                PH_COPYVAL:
                begin
                    left_next  = copy_left;
                    phase_next = (copy_left == '0) ? PH_ADDR : PH_COPYVAL;
                end
                default:
                begin
                    phase_next = PH_ADDR;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        emit     = 1'b0;
        emit_req = '{reg_addr: addr_reg, reg_value: q_data.word, repeat_count: 15'd1};
        case (cur_phase)
            PH_RUNVAL:
            begin
                emit                  = (cur_left != '0);
                emit_req.repeat_count = cur_left;
            end
            PH_COPYVAL:
            begin
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (out_free)
        begin
            out_vld_next = q_pop && emit;
            out_next     = emit_req;
        end
    end

    assign wr_valid = out_vld_reg;
    assign wr_req   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_ADDR;
            left_reg    <= '0;
            addr_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            addr_reg    <= addr_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

/* src/rle_register_image_loader.sv */
// ----------------------------------------------------------------------------
// rle_register_image_loader: run-length register image parser
//
// Input channel (byte_valid / byte_stall / byte_req): one image byte per
// request, stream_start set on the first byte of each image. Bytes pair into
// little-endian words; records are address, count, then value words.
// Output channel (wr_valid / wr_stall / wr_req): one register write per
// request; runs come out once with their repeat count, not expanded.
// Throughput: one byte per cycle while byte_stall is low, since a word takes
// two bytes and the parser retires one word per cycle while the output is
// not stalled. A write's word enters the queue when its last byte is taken,
// then moves through the parser into the output register behind wr_valid.
// A stalled output holds its request; the parser waits, the word queue
// (QUEUE_DEPTH words) fills, and then byte_stall rises.
// Reset clears the byte pairing, parser phase, queue and output valid; the
// first image must still open with stream_start.
// ----------------------------------------------------------------------------
module rle_register_image_loader
    import rril_pkg::*;
#(
    parameter int QUEUE_DEPTH = WORD_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  byte_req_t byte_req,
    output logic      wr_valid,
    input  logic      wr_stall,
    output reg_wr_t   wr_req
);

    queue_stat_t q_stat;
    logic        q_push;
    logic        q_pop;
    word_entry_t q_push_data;
    word_entry_t q_pop_data;

    // Front: pairs bytes, marks restart words.
    rril_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_req   (byte_req),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    // Word queue decouples byte intake from output stalls.
    rril_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    // Back: record parsing and the registered write request.
    rril_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .wr_valid (wr_valid),
        .wr_stall (wr_stall),
        .wr_req   (wr_req)
    );

endmodule
